// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks shared by the blur block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is high
`define RFNB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// check that also holds across reset
`define RFNB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("%m: check failed");

`endif

// File: src/rfnb_pkg.sv
// ----------------------------------------------------------------------------
// rfnb_pkg
// shared types and constants of the four neighbor blur
// ----------------------------------------------------------------------------
package rfnb_pkg;

   // frame size limits and field widths
   localparam int SIZE_LIMIT  = 1024;
   localparam int DIM_W       = 11;
   localparam int POS_W       = 10;
   localparam int CHAN_W      = 8;
   localparam int CSR_INDEX_W = 1;

   // queue depths
   localparam int TASK_DEPTH  = 4;
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_LEVEL_W = $clog2(RSP_DEPTH) + 1;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT
   } csr_index_type;

   // one input pixel
   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_type;

   // one blurred result
   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic [POS_W-1:0]  out_row;
      logic [POS_W-1:0]  out_column;
      logic              run_end;
      logic              frame_end;
   } rsp_type;

   localparam int PIX_W = $bits(req_type);
   localparam int RSP_W = $bits(rsp_type);

   // results owed by one pixel, oldest first: above, left, corner
   typedef struct packed {
      logic corner;
      logic left;
      logic above;
   } emit_type;

   // classified pixel handed from front to back
   typedef struct packed {
      req_type          pixel;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] column;
      logic             up_valid;
      logic             left_valid;
      logic             right_valid;
      logic             far_left_valid;
      emit_type         emit;
   } task_type;

   localparam int TASK_W = $bits(task_type);

endpackage

// File: src/rfnb_ram.sv
// ----------------------------------------------------------------------------
// rfnb_ram
// simple dual port ram, one write and one registered read-first read
// ----------------------------------------------------------------------------
module rfnb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/rfnb_fifo.sv
// ----------------------------------------------------------------------------
// rfnb_fifo
// small register queue with full, empty and fill level
// ----------------------------------------------------------------------------
module rfnb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   output logic                     full,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output logic                     empty,
   output logic [$clog2(DEPTH):0]   level
);

   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign level    = count_ff;
   assign pop_data = entries_ff[rd_ptr_ff];

   // pointer and level update
   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/rfnb_front.sv
// ----------------------------------------------------------------------------
// rfnb_front
// frame size registers, raster position and per-pixel classification
// ----------------------------------------------------------------------------
module rfnb_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  rfnb_pkg::req_type                  req_data,
   input  logic                               csr_write_en,
   input  logic [rfnb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rfnb_pkg::DIM_W-1:0]         csr_data,
   output logic                               task_push,
   output rfnb_pkg::task_type                 task_data,
   input  logic                               task_full
);

   localparam int WIDTH_TOP = (MAX_WIDTH < rfnb_pkg::SIZE_LIMIT) ?
                              MAX_WIDTH : rfnb_pkg::SIZE_LIMIT;
   localparam int DW = rfnb_pkg::DIM_W;
   localparam int PW = rfnb_pkg::POS_W;

   logic [DW-1:0] width_ff, width_in;
   logic [DW-1:0] height_ff, height_in;
   logic [PW-1:0] row_ff, row_in;
   logic [PW-1:0] col_ff, col_in;
   logic [DW-1:0] col_next, row_next;
   logic          accept, last_col, last_row;

   function automatic logic [DW-1:0] clamp_size(input logic [DW-1:0] v,
                                                input logic [DW-1:0] top);
      logic [DW-1:0] r;
      r = v;
      if (v < DW'(2)) begin
         r = DW'(2);
      end else if (v > top) begin
         r = top;
      end
      return r;
   endfunction

   assign full   = task_full;
   assign accept = push && !task_full;

   // position of the incoming pixel within the frame
   always_comb begin
      col_next = {1'b0, col_ff} + DW'(1);
      row_next = {1'b0, row_ff} + DW'(1);
      last_col = (col_next == width_ff);
      last_row = (row_next == height_ff);
   end

   // register writes and raster counters
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (csr_write_en) begin
         unique case (rfnb_pkg::csr_index_type'(csr_index))
            rfnb_pkg::CSR_FRAME_WIDTH: begin
               width_in = clamp_size(csr_data, DW'(WIDTH_TOP));
            end
            rfnb_pkg::CSR_FRAME_HEIGHT: begin
               height_in = clamp_size(csr_data, DW'(rfnb_pkg::SIZE_LIMIT));
            end
         endcase
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[PW-1:0];
         end else begin
            col_in = col_next[PW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DW'(WIDTH_TOP);
         height_ff <= DW'(rfnb_pkg::SIZE_LIMIT);
         row_ff    <= '0;
         col_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
      end
   end

   // neighbor availability and results owed by this pixel
   always_comb begin
      task_push                = accept;
      task_data.pixel          = req_data;
      task_data.row            = row_ff;
      task_data.column         = col_ff;
      task_data.up_valid       = (row_ff > PW'(1));
      task_data.left_valid     = (col_ff != '0);
      task_data.right_valid    = !last_col;
      task_data.far_left_valid = (col_ff > PW'(1));
      task_data.emit.above     = (row_ff != '0);
      task_data.emit.left      = last_row && (col_ff != '0);
      task_data.emit.corner    = last_row && last_col;
   end

endmodule

// File: src/rfnb_back.sv
// ----------------------------------------------------------------------------
// rfnb_back
// line stores, neighbor window, result sequencing and averaging
// ----------------------------------------------------------------------------
module rfnb_back #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               task_empty,
   output logic                               task_pop,
   input  rfnb_pkg::task_type                 task_data,
   input  logic [rfnb_pkg::RSP_LEVEL_W-1:0]   rsp_level,
   output logic                               rsp_push,
   output rfnb_pkg::rsp_type                  rsp_data
);

   localparam int STORE_DEPTH = (MAX_WIDTH < rfnb_pkg::SIZE_LIMIT) ?
                                MAX_WIDTH : rfnb_pkg::SIZE_LIMIT;
   localparam int AW         = $clog2(STORE_DEPTH);
   localparam int PW         = rfnb_pkg::POS_W;
   localparam int CW         = rfnb_pkg::CHAN_W;
   localparam int SUM_W      = CW + 2;
   localparam int DIV3_RECIP = 683;
   localparam int DIV3_SHIFT = 11;
   localparam int PROD_W     = SUM_W + 10;
   localparam int OCC_W      = rfnb_pkg::RSP_LEVEL_W + 1;

   typedef enum logic [1:0] {
      DIV_BY_2,
      DIV_BY_3,
      DIV_BY_4
   } div_type;

   typedef struct packed {
      logic [SUM_W-1:0] red_sum;
      logic [SUM_W-1:0] green_sum;
      logic [SUM_W-1:0] blue_sum;
      div_type          div;
      logic [PW-1:0]    row;
      logic [PW-1:0]    column;
      logic             run_end;
      logic             frame_end;
   } sum_type;

   // work stage
   logic                b_valid_ff, b_valid_in;
   rfnb_pkg::task_type  b_task_ff, b_task_in;
   rfnb_pkg::emit_type  pend_ff, pend_in, pend_clear;

   // neighbor window: previous row and current row
   rfnb_pkg::req_type   win_m1_ff, win_m1_in;
   rfnb_pkg::req_type   win_0_ff, win_0_in;
   rfnb_pkg::req_type   first_ff, first_in;
   rfnb_pkg::req_type   pix_m1_ff, pix_m1_in;
   rfnb_pkg::req_type   pix_m2_ff, pix_m2_in;

   // averaging stage
   logic                c_valid_ff, c_valid_in;
   sum_type             c_sum_ff, c_sum_in;

   // line store ports
   logic [rfnb_pkg::PIX_W-1:0] store_a_rd_data, store_b_rd_data;
   logic [AW-1:0]              col_addr, next_addr, store_a_rd_addr, store_b_rd_addr;
   logic [PW-1:0]              col_plus;
   logic                       store_a_wr_en, store_b_wr_en;

   rfnb_pkg::req_type   ram_up, ram_right, prev_c, prev_cm1, pix;
   rfnb_pkg::req_type   op [4];
   logic [3:0]          op_valid;
   logic [2:0]          op_count;
   logic [SUM_W-1:0]    red_acc, green_acc, blue_acc;
   logic [OCC_W-1:0]    occupancy;
   logic                kind_above, kind_left, kind_corner;
   logic                has_pend, issue_ok, emit, b_leave;

   // line store addressing: even rows in store a, odd rows in store b
   always_comb begin
      col_plus        = task_data.column + PW'(1);
      col_addr        = task_data.column[AW-1:0];
      next_addr       = col_plus[AW-1:0];
      store_a_wr_en   = task_pop && !task_data.row[0];
      store_b_wr_en   = task_pop && task_data.row[0];
      store_a_rd_addr = task_data.row[0] ? next_addr : col_addr;
      store_b_rd_addr = task_data.row[0] ? col_addr : next_addr;
   end

   rfnb_ram #(
      .WIDTH (rfnb_pkg::PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_line_store_a (
      .clock   (clock),
      .wr_en   (store_a_wr_en),
      .wr_addr (col_addr),
      .wr_data (task_data.pixel),
      .rd_en   (task_pop),
      .rd_addr (store_a_rd_addr),
      .rd_data (store_a_rd_data)
   );

   rfnb_ram #(
      .WIDTH (rfnb_pkg::PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_line_store_b (
      .clock   (clock),
      .wr_en   (store_b_wr_en),
      .wr_addr (col_addr),
      .wr_data (task_data.pixel),
      .rd_en   (task_pop),
      .rd_addr (store_b_rd_addr),
      .rd_data (store_b_rd_data)
   );

   // pick the owed result and the handshake of the work stage
   always_comb begin
      has_pend    = pend_ff.above || pend_ff.left || pend_ff.corner;
      kind_above  = pend_ff.above;
      kind_left   = !pend_ff.above && pend_ff.left;
      kind_corner = !pend_ff.above && !pend_ff.left && pend_ff.corner;
      pend_clear  = pend_ff;
      if (pend_ff.above) begin
         pend_clear.above = 1'b0;
      end else if (pend_ff.left) begin
         pend_clear.left = 1'b0;
      end else begin
         pend_clear.corner = 1'b0;
      end
      occupancy = {1'b0, rsp_level} + OCC_W'(c_valid_ff);
      issue_ok  = (occupancy < OCC_W'(rfnb_pkg::RSP_DEPTH));
      emit      = b_valid_ff && has_pend && issue_ok;
      b_leave   = b_valid_ff && (!has_pend || (emit && (pend_clear == '0)));
      task_pop  = !task_empty && (!b_valid_ff || b_leave);
   end

   // neighbor words for the pixel in the work stage
   always_comb begin
      pix       = b_task_ff.pixel;
      ram_up    = b_task_ff.row[0] ? rfnb_pkg::req_type'(store_b_rd_data) :
                                     rfnb_pkg::req_type'(store_a_rd_data);
      ram_right = b_task_ff.row[0] ? rfnb_pkg::req_type'(store_a_rd_data) :
                                     rfnb_pkg::req_type'(store_b_rd_data);
      prev_c    = (b_task_ff.column == '0) ? first_ff : win_0_ff;
      prev_cm1  = win_m1_ff;
   end

   // operand slots of the selected result
   always_comb begin
      op[0] = kind_above ? ram_up : (kind_left ? prev_cm1 : prev_c);
      op[1] = kind_above ? prev_cm1 : (kind_left ? pix_m2_ff : pix_m1_ff);
      op[2] = kind_above ? ram_right : pix;
      op[3] = pix;
      op_valid[0] = kind_above ? b_task_ff.up_valid : 1'b1;
      op_valid[1] = kind_above ? b_task_ff.left_valid :
                    (kind_left ? b_task_ff.far_left_valid : 1'b1);
      op_valid[2] = kind_above ? b_task_ff.right_valid : kind_left;
      op_valid[3] = kind_above;
   end

   // channel sums and divisor
   always_comb begin
      red_acc   = '0;
      green_acc = '0;
      blue_acc  = '0;
      op_count  = '0;
      for (int k = 0; k < 4; k++) begin
         if (op_valid[k]) begin
            red_acc   = red_acc + SUM_W'(op[k].red_in);
            green_acc = green_acc + SUM_W'(op[k].green_in);
            blue_acc  = blue_acc + SUM_W'(op[k].blue_in);
            op_count  = op_count + 3'(1);
         end
      end
      c_sum_in.red_sum   = red_acc;
      c_sum_in.green_sum = green_acc;
      c_sum_in.blue_sum  = blue_acc;
      case (op_count)
         3'd2:    c_sum_in.div = DIV_BY_2;
         3'd3:    c_sum_in.div = DIV_BY_3;
         default: c_sum_in.div = DIV_BY_4;
      endcase
      c_sum_in.row       = kind_above ? b_task_ff.row - PW'(1) : b_task_ff.row;
      c_sum_in.column    = kind_left ? b_task_ff.column - PW'(1) : b_task_ff.column;
      c_sum_in.run_end   = (pend_clear == '0);
      c_sum_in.frame_end = kind_corner;
      c_valid_in         = emit;
   end

   // next values of the work stage and the window
   always_comb begin
      b_valid_in = b_valid_ff;
      b_task_in  = b_task_ff;
      pend_in    = pend_ff;
      win_m1_in  = win_m1_ff;
      win_0_in   = win_0_ff;
      first_in   = first_ff;
      pix_m1_in  = pix_m1_ff;
      pix_m2_in  = pix_m2_ff;
      if (emit) begin
         pend_in = pend_clear;
      end
      if (b_leave) begin
         b_valid_in = 1'b0;
         win_m1_in  = prev_c;
         win_0_in   = ram_right;
         pix_m1_in  = pix;
         pix_m2_in  = pix_m1_ff;
         if (b_task_ff.column == '0) begin
            first_in = pix;
         end
      end
      if (task_pop) begin
         b_valid_in = 1'b1;
         b_task_in  = task_data;
         pend_in    = task_data.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         pend_ff    <= '0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         pend_ff    <= pend_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_task_ff <= b_task_in;
      win_m1_ff <= win_m1_in;
      win_0_ff  <= win_0_in;
      first_ff  <= first_in;
      pix_m1_ff <= pix_m1_in;
      pix_m2_ff <= pix_m2_in;
      c_sum_ff  <= c_sum_in;
   end

   // truncated mean of two, three or four neighbors
   function automatic logic [CW-1:0] chan_mean(input logic [SUM_W-1:0] s,
                                               input div_type d);
      logic [PROD_W-1:0] prod;
      logic [CW-1:0]     q;
      prod = '0;
      unique case (d)
         DIV_BY_2: q = s[CW:1];
         DIV_BY_3: begin
            prod = PROD_W'(s) * PROD_W'(DIV3_RECIP);
            q    = prod[DIV3_SHIFT+CW-1:DIV3_SHIFT];
         end
         DIV_BY_4: q = s[CW+1:2];
         default:  q = s[CW:1];
      endcase
      return q;
   endfunction

   // result transfer into the output queue
   always_comb begin
      rsp_push            = c_valid_ff;
      rsp_data.red_out    = chan_mean(c_sum_ff.red_sum, c_sum_ff.div);
      rsp_data.green_out  = chan_mean(c_sum_ff.green_sum, c_sum_ff.div);
      rsp_data.blue_out   = chan_mean(c_sum_ff.blue_sum, c_sum_ff.div);
      rsp_data.out_row    = c_sum_ff.row;
      rsp_data.out_column = c_sum_ff.column;
      rsp_data.run_end    = c_sum_ff.run_end;
      rsp_data.frame_end  = c_sum_ff.frame_end;
   end

endmodule

// File: src/rgb_four_neighbor_blur.sv
// ----------------------------------------------------------------------------
// rgb_four_neighbor_blur: four neighbor average blur over a raster rgb stream
// throughput: 1 pixel per cycle while the result queue has room
// a last-row pixel owing 2 or 3 results holds the work stage until each is issued
// reset: synchronous; clears queues and counters, sizes go to max, stores not cleared
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_four_neighbor_blur #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  rfnb_pkg::req_type                  req_data,
   output logic                               empty,
   input  logic                               pop,
   output rfnb_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write_en,
   input  logic [rfnb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rfnb_pkg::DIM_W-1:0]         csr_data
);

   logic                               task_push, task_full, task_empty, task_pop;
   rfnb_pkg::task_type                 task_in, task_out;
   logic                               rsp_push, rsp_full;
   rfnb_pkg::rsp_type                  rsp_in;
   logic [rfnb_pkg::RSP_LEVEL_W-1:0]   rsp_level;

   // position tracking and classification
   rfnb_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .task_push    (task_push),
      .task_data    (task_in),
      .task_full    (task_full)
   );

   // queue between front and back
   rfnb_fifo #(
      .WIDTH (rfnb_pkg::TASK_W),
      .DEPTH (rfnb_pkg::TASK_DEPTH)
   ) u_task_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (task_push),
      .push_data (task_in),
      .full      (task_full),
      .pop       (task_pop),
      .pop_data  (task_out),
      .empty     (task_empty),
      .level     ()
   );

   // line stores and averaging
   rfnb_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .task_empty (task_empty),
      .task_pop   (task_pop),
      .task_data  (task_out),
      .rsp_level  (rsp_level),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_in)
   );

   // result queue
   rfnb_fifo #(
      .WIDTH (rfnb_pkg::RSP_W),
      .DEPTH (rfnb_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty),
      .level     (rsp_level)
   );

   // checks
   `RFNB_ASSERT(rsp_credit_holds, clock, reset, rsp_push |-> !rsp_full)
   `RFNB_ASSERT(frame_end_closes_run, clock, reset, rsp_push && rsp_in.frame_end |-> rsp_in.run_end)
   `RFNB_ASSERT_ALWAYS(reset_drains_queues, clock, reset |=> empty && !full)

endmodule

// File: tb/rgb_four_neighbor_blur_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_four_neighbor_blur_tb
// self-checking bench for the four neighbor blur: raster frames of random
// pixels are pushed through the block under several frame sizes and idle
// patterns, and every blurred result is checked against an in-bench model
// ----------------------------------------------------------------------------
module rgb_four_neighbor_blur_tb;

   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned WATCHDOG_MAX  = 3000;
   localparam int unsigned PHASE_PIXELS  = 62;
   localparam int          DW            = rfnb_pkg::DIM_W;
   localparam int          PW            = rfnb_pkg::POS_W;
   localparam int          LIMIT         = rfnb_pkg::SIZE_LIMIT;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #10 clock = ~clock;

   // block ports
   logic                                push = 1'b0;
   logic                                full;
   rfnb_pkg::req_type                   req_data = '0;
   logic                                empty;
   logic                                pop = 1'b0;
   rfnb_pkg::rsp_type                   rsp_data;
   logic                                csr_write_en = 1'b0;
   logic [rfnb_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [DW-1:0]                       csr_data = '0;

   rgb_four_neighbor_blur u_dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_data     (req_data),
      .empty        (empty),
      .pop          (pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // stimulus and expectation stores
   rfnb_pkg::req_type     pixel_queue [$];
   rfnb_pkg::rsp_type     expected_blur [$];

   // model state: sizes, raster position, two row stores by row parity
   logic [DW-1:0]    cfg_width  = DW'(LIMIT);
   logic [DW-1:0]    cfg_height = DW'(LIMIT);
   int unsigned      row_pos = 0;
   int unsigned      col_pos = 0;
   logic [23:0]      rows_even [LIMIT];
   logic [23:0]      rows_odd  [LIMIT];

   // run control and statistics
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned error_count = 0;
   int unsigned pixels_sent = 0;
   int unsigned results_checked = 0;
   int unsigned frames_done = 0;
   int unsigned csr_writes = 0;
   int unsigned held_off_cycles = 0;
   int unsigned quiet_cycles = 0;

   // size actually used by the block for a register value
   function automatic int unsigned eff_size(input logic [DW-1:0] v);
      if (v < 2) return 2;
      if (v > LIMIT) return LIMIT;
      return v;
   endfunction

   function automatic logic [23:0] stored(input int unsigned row, input int unsigned col);
      return row[0] ? rows_odd[col] : rows_even[col];
   endfunction

   // per-channel sums, 10 bits each, red on top
   function automatic logic [29:0] add_px(input logic [29:0] acc, input logic [23:0] p);
      return {acc[29:20] + 10'(p[23:16]), acc[19:10] + 10'(p[15:8]),
              acc[9:0] + 10'(p[7:0])};
   endfunction

   function automatic rfnb_pkg::rsp_type blur_of(input logic [29:0] acc,
                                                 input int unsigned n,
                                                 input int unsigned row,
                                                 input int unsigned col,
                                                 input logic fend);
      rfnb_pkg::rsp_type res;
      res.red_out    = 8'(32'(acc[29:20]) / n);
      res.green_out  = 8'(32'(acc[19:10]) / n);
      res.blue_out   = 8'(32'(acc[9:0]) / n);
      res.out_row    = PW'(row);
      res.out_column = PW'(col);
      res.run_end    = 1'b0;
      res.frame_end  = fend;
      return res;
   endfunction

   // blur results owed by one accepted pixel, oldest first
   task automatic predict_blur(input rfnb_pkg::req_type px);
      logic [23:0]       pix;
      logic [29:0]       acc;
      rfnb_pkg::rsp_type outs [3];
      int unsigned       w, h, r, c, n, cnt;
      w = eff_size(cfg_width);
      h = eff_size(cfg_height);
      r = row_pos;
      c = col_pos;
      pix = px;
      cnt = 0;
      // pixel above: this input is its lower neighbor
      if (r > 0) begin
         acc = add_px('0, pix);
         n = 1;
         if (r > 1) begin
            acc = add_px(acc, stored(r, c));
            n++;
         end
         if (c > 0) begin
            acc = add_px(acc, stored(r - 1, c - 1));
            n++;
         end
         if (c + 1 < w) begin
            acc = add_px(acc, stored(r - 1, c + 1));
            n++;
         end
         outs[cnt] = blur_of(acc, n, r - 1, c, 1'b0);
         cnt++;
      end
      if (r[0]) rows_odd[c] = pix;
      else rows_even[c] = pix;
      // last row: left pixel now has its right neighbor, then the corner
      if (r + 1 == h) begin
         if (c > 0) begin
            acc = add_px(add_px('0, stored(r - 1, c - 1)), pix);
            n = 2;
            if (c > 1) begin
               acc = add_px(acc, stored(r, c - 2));
               n++;
            end
            outs[cnt] = blur_of(acc, n, r, c - 1, 1'b0);
            cnt++;
         end
         if (c + 1 == w) begin
            acc = add_px(add_px('0, stored(r - 1, c)), stored(r, c - 1));
            outs[cnt] = blur_of(acc, 2, r, c, 1'b1);
            cnt++;
         end
      end
      for (int i = 0; i < cnt; i++) begin
         if (i == cnt - 1) outs[i].run_end = 1'b1;
         expected_blur.push_back(outs[i]);
      end
      // advance raster position
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result(input rfnb_pkg::rsp_type got);
      rfnb_pkg::rsp_type want;
      if (expected_blur.size() == 0) begin
         $error("result with none expected: row %0d column %0d", got.out_row,
                got.out_column);
         error_count++;
      end else begin
         want = expected_blur.pop_front();
         compare_field("red_out", want.red_out, got.red_out);
         compare_field("green_out", want.green_out, got.green_out);
         compare_field("blue_out", want.blue_out, got.blue_out);
         compare_field("out_row", want.out_row, got.out_row);
         compare_field("out_column", want.out_column, got.out_column);
         compare_field("run_end", want.run_end, got.run_end);
         compare_field("frame_end", want.frame_end, got.frame_end);
         results_checked++;
         if (want.frame_end) frames_done++;
      end
   endtask

   // input driver: one pixel transfer per push/!full edge
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) predict_blur(req_data);
         if (push && full) begin
            held_off_cycles++;
         end else if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            push <= 1'b1;
            req_data <= pixel_queue.pop_front();
            pixels_sent++;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // result monitor with random stalls and an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_result(rsp_data);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // register write; block is idle so the model follows at once
   task automatic write_csr(input rfnb_pkg::csr_index_type idx, input int unsigned value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value[DW-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == rfnb_pkg::CSR_FRAME_WIDTH) cfg_width = value[DW-1:0];
      else cfg_height = value[DW-1:0];
      row_pos = 0;
      col_pos = 0;
      csr_writes++;
   endtask

   task automatic set_frame(input int unsigned w, input int unsigned h);
      write_csr(rfnb_pkg::CSR_FRAME_WIDTH, w);
      write_csr(rfnb_pkg::CSR_FRAME_HEIGHT, h);
   endtask

   // wait for every transfer and expected result, plus pipeline slack
   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_queue.size() != 0 || push || expected_blur.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic rfnb_pkg::req_type random_pixel();
      logic [7:0] ch [3];
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(9))
            0: ch[i] = 8'h00;
            1: ch[i] = 8'hFF;
            default: ch[i] = 8'($urandom_range(255));
         endcase
      end
      return {ch[0], ch[1], ch[2]};
   endfunction

   task automatic queue_random(input int unsigned count);
      for (int i = 0; i < count; i++) pixel_queue.push_back(random_pixel());
   endtask

   // mostly in range, sometimes below the minimum
   function automatic int unsigned random_size(input int unsigned lo, input int unsigned hi);
      case ($urandom_range(9))
         0: return $urandom_range(1);
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   // test sequence
   initial begin
      int unsigned idle_plan [4];
      int unsigned stall_plan [4];
      int unsigned phase_count, w, h, frame_pixels, n;
      idle_plan  = '{0, 57, 0, 25};
      stall_plan = '{0, 0, 57, 25};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: a few first-row pixels that owe nothing, then restart
      queue_random(6);
      wait_drained();

      // smallest frame: corners only
      set_frame(2, 2);
      pixel_queue.push_back(24'h000000);
      pixel_queue.push_back(24'hFFFFFF);
      pixel_queue.push_back(24'hFF00FF);
      pixel_queue.push_back(24'h00FF00);
      wait_drained();

      // 3x3: corners, edges and one interior pixel with four neighbors
      set_frame(3, 3);
      pixel_queue.push_back(24'hFF0000);
      pixel_queue.push_back(24'h00FF00);
      pixel_queue.push_back(24'h0000FF);
      pixel_queue.push_back(24'h123456);
      pixel_queue.push_back(24'hFFFFFF);
      pixel_queue.push_back(24'h000000);
      pixel_queue.push_back(24'h807F01);
      pixel_queue.push_back(24'hFEFDFC);
      pixel_queue.push_back(24'h010203);
      wait_drained();

      // sizes below the minimum act as 2
      set_frame(0, 1);
      pixel_queue.push_back(24'hFFFFFF);
      pixel_queue.push_back(24'hFFFFFF);
      pixel_queue.push_back(24'hFFFFFF);
      pixel_queue.push_back(24'hFFFFFF);
      wait_drained();

      // random frames under each idle pattern
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = idle_plan[p];
         receiver_stall_pct = stall_plan[p];
         phase_count = 0;
         while (phase_count < PHASE_PIXELS) begin
            w = random_size(2, 9);
            h = random_size(2, 6);
            if ($urandom_range(1)) set_frame(w, h);
            else begin
               write_csr(rfnb_pkg::CSR_FRAME_HEIGHT, h);
               write_csr(rfnb_pkg::CSR_FRAME_WIDTH, w);
            end
            frame_pixels = eff_size(w[DW-1:0]) * eff_size(h[DW-1:0]);
            // mostly whole frames, back to back; sometimes cut short
            if ($urandom_range(4) == 0) n = $urandom_range(1, frame_pixels - 1);
            else n = frame_pixels * $urandom_range(1, 2);
            if (n > PHASE_PIXELS - phase_count) n = PHASE_PIXELS - phase_count;
            queue_random(n);
            phase_count += n;
            wait_drained();
         end
      end

      // receiver holds off while the sender keeps offering
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      set_frame(6, 6);
      @(negedge clock);
      hold_requests++;
      queue_random(72);
      wait_drained();

      // oversize values: a tall frame cut short, then the widest first row
      sender_idle_pct = 10;
      receiver_stall_pct = 10;
      set_frame(4, 2047);
      queue_random(24);
      wait_drained();
      set_frame(2047, 2);
      queue_random(10);
      wait_drained();

      $display("covered %0d pixels and %0d checked results over %0d complete frames",
               pixels_sent, results_checked, frames_done);
      $display("%0d register writes; input held off by a full block for %0d cycles",
               csr_writes, held_off_cycles);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
